>>> design/sls_pkg.sv
// Shared constants, widths and types for the sound level offset smoother.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sls_pkg;

    localparam int WINDOW    = 15;
    localparam int CAL_COUNT = 10;
    localparam int BIAS_RESET = 100;

    localparam int SAMPLE_W = 10;
    localparam int DEV_W    = SAMPLE_W + 1;
    localparam int SUM_W    = DEV_W + $clog2(WINDOW);
    localparam int CAL_IDX_W = $clog2(CAL_COUNT);
    localparam int CAL_DIV   = CAL_COUNT - 1;
    localparam int CAL_SUM_W = SAMPLE_W + $clog2(CAL_DIV);

    // Reciprocal constants: floor(x / d) == (x * RECIP) >> SHIFT for every x that
    // fits the dividend width, since the rounding error of RECIP stays below d.
    localparam int CAL_SHIFT   = CAL_SUM_W + $clog2(CAL_DIV);
    localparam longint CAL_RECIP = ((64'd1 << CAL_SHIFT) + CAL_DIV - 1) / CAL_DIV;
    localparam int CAL_RECIP_W = CAL_SHIFT - $clog2(CAL_DIV) + 1;

    localparam int WIN_SHIFT   = SUM_W + $clog2(WINDOW);
    localparam longint WIN_RECIP = ((64'd1 << WIN_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int WIN_RECIP_W = WIN_SHIFT - $clog2(WINDOW) + 1;

    typedef enum logic
    {
        OP_CAL  = 1'b0,
        OP_MEAS = 1'b1
    } op_t;

    // One write into a unit: enable and data.
    typedef struct packed
    {
        logic                en;
        logic [SAMPLE_W-1:0] sample;
    } cal_push_t;

    typedef struct packed
    {
        logic             en;
        logic [DEV_W-1:0] dev;
    } win_push_t;

endpackage

>>> design/sls_cell.sv
// One stage of the deviation window: holds a single entry and passes it on.
// Depends on sls_pkg for the entry width.
`timescale 1ns / 1ps

module sls_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      shift,
    input  logic [sls_pkg::DEV_W-1:0] d,
    output logic [sls_pkg::DEV_W-1:0] q
);
    import sls_pkg::*;

    logic [DEV_W-1:0] entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= d;
        end
    end

    assign q = entry_reg;

endmodule

>>> design/sls_window.sv
// Deviation window: a chain of sls_cell stages plus the running window sum.
// Depends on sls_pkg and sls_cell.
`timescale 1ns / 1ps

module sls_window
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sls_pkg::win_push_t        push,
    output logic [sls_pkg::SUM_W-1:0] sum_next
);
    import sls_pkg::*;

    logic [DEV_W-1:0] tap [WINDOW+1];
    logic [SUM_W-1:0] sum_reg;

    assign tap[0] = push.dev;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        sls_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (push.en),
            .d     (tap[i]),
            .q     (tap[i+1])
        );
    end

    // The oldest entry leaves as the new deviation enters.
    always_comb
    begin
        if (push.en)
        begin
            sum_next = sum_reg - SUM_W'(tap[WINDOW]) + SUM_W'(push.dev);
        end
        else
        begin
            sum_next = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

>>> design/sls_cal.sv
// Calibration unit: counts a run of samples, sums all but the first, and forms
// the offset from the run average plus the bias. Depends on sls_pkg.
`timescale 1ns / 1ps

module sls_cal
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sls_pkg::cal_push_t           push,
    input  logic [sls_pkg::SAMPLE_W-1:0] bias,
    output logic [sls_pkg::DEV_W-1:0]    offset_now,
    output logic [sls_pkg::DEV_W-1:0]    offset_next
);
    import sls_pkg::*;

    logic [CAL_IDX_W-1:0] idx_reg;
    logic [CAL_IDX_W-1:0] idx_next;
    logic [CAL_SUM_W-1:0] sum_reg;
    logic [CAL_SUM_W-1:0] sum_next;
    logic [CAL_SUM_W-1:0] sum_add;
    logic [DEV_W-1:0]     offset_reg;
    logic [CAL_SUM_W+CAL_RECIP_W-1:0] prod;
    logic [SAMPLE_W-1:0]  avg;
    logic                 last;

    // The first sample of a run is dropped.
    assign sum_add = (idx_reg != '0) ? sum_reg + CAL_SUM_W'(push.sample) : sum_reg;
    assign last    = (idx_reg >= CAL_IDX_W'(CAL_DIV));
    assign prod    = sum_add * CAL_RECIP_W'(CAL_RECIP);
    assign avg     = prod[CAL_SHIFT +: SAMPLE_W];

    always_comb
    begin
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        offset_next = offset_reg;
        if (push.en)
        begin
            if (last)
            begin
                idx_next    = '0;
                sum_next    = '0;
                offset_next = DEV_W'(avg) + DEV_W'(bias);
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                sum_next = sum_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            sum_reg    <= '0;
            offset_reg <= '0;
        end
        else
        begin
            idx_reg    <= idx_next;
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
        end
    end

    assign offset_now = offset_reg;

endmodule

>>> design/sound_level_offset_smoother.sv
// Top level of the sound level offset smoother: handshake, bias register,
// result pipeline and window average. Depends on sls_pkg, sls_cal, sls_window.
//
//   channel   direction  handshake               payload
//   in        input      in_valid / in_ready     op, sample
//   out       output     out_valid / out_ready   level, offset
//   cfg       input      cfg_write               cfg_data (offset bias)
//
// One item is taken per cycle unless the output stalls with stage 1 full.
// State (calibration run, offset, window cells, window sum) updates at the input
// transfer; a second stage divides the window sum by the window depth.
// Reset clears the window, the calibration run and the offset, and sets the bias
// to 100. A stalled output holds its result while one more item moves up behind it.
`timescale 1ns / 1ps

module sound_level_offset_smoother
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [sls_pkg::SAMPLE_W-1:0] sample,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [sls_pkg::DEV_W-1:0]    level,
    output logic [sls_pkg::DEV_W-1:0]    offset,
    input  logic                         cfg_write,
    input  logic [sls_pkg::SAMPLE_W-1:0] cfg_data
);
    import sls_pkg::*;

    logic [SAMPLE_W-1:0] bias_reg;
    logic                accept;
    logic                out_free;
    cal_push_t           cal_push;
    win_push_t           win_push;
    logic [DEV_W-1:0]    offset_now;
    logic [DEV_W-1:0]    offset_next;
    logic [SUM_W-1:0]    win_sum_next;
    logic [DEV_W-1:0]    dev;

    logic                s1_valid_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [DEV_W-1:0]    s1_offset_reg;
    logic                out_valid_reg;
    logic [DEV_W-1:0]    level_reg;
    logic [DEV_W-1:0]    offset_reg;
    logic [SUM_W+WIN_RECIP_W-1:0] level_prod;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || out_free;
    assign accept   = in_valid && in_ready;

    assign dev = (DEV_W'(sample) >= offset_now) ? DEV_W'(sample) - offset_now
                                                : offset_now - DEV_W'(sample);

    assign cal_push.en     = accept && (op == OP_CAL);
    assign cal_push.sample = sample;
    assign win_push.en     = accept && (op == OP_MEAS);
    assign win_push.dev    = dev;

    sls_cal u_cal
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (cal_push),
        .bias        (bias_reg),
        .offset_now  (offset_now),
        .offset_next (offset_next)
    );

    sls_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (win_push),
        .sum_next (win_sum_next)
    );

    assign level_prod = s1_sum_reg * WIN_RECIP_W'(WIN_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= SAMPLE_W'(BIAS_RESET);
        end
        else if (cfg_write)
        begin
            bias_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= accept;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sum_reg    <= win_sum_next;
            s1_offset_reg <= offset_next;
        end
        if (out_free && s1_valid_reg)
        begin
            level_reg  <= level_prod[WIN_SHIFT +: DEV_W];
            offset_reg <= s1_offset_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;
    assign offset    = offset_reg;

endmodule

>>> tb/tb_sound_level_offset_smoother.sv
// Self-checking testbench for sound_level_offset_smoother: a scoreboard class predicts
// the level and offset of every input transfer and checks each output transfer.
// Depends on sls_pkg and the sound_level_offset_smoother RTL.
`timescale 1ns / 1ps

module tb_sound_level_offset_smoother;
    import sls_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed
    {
        logic [DEV_W-1:0] level;
        logic [DEV_W-1:0] offset;
    } level_result_t;

    class level_scoreboard;
        logic [SAMPLE_W-1:0] bias;
        logic [DEV_W-1:0]    taps[WINDOW];
        logic [SUM_W-1:0]    tap_sum;
        logic [3:0]          cal_pos;
        logic [13:0]         cal_acc;
        logic [DEV_W-1:0]    cur_offset;
        level_result_t       expected_q[$];
        int                  failures;

        function new();
            bias = SAMPLE_W'(BIAS_RESET);
            foreach (taps[i])
                taps[i] = '0;
            tap_sum    = '0;
            cal_pos    = '0;
            cal_acc    = '0;
            cur_offset = '0;
            failures   = 0;
        endfunction

        function void set_bias(logic [SAMPLE_W-1:0] value);
            bias = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one accepted input and queue its result.
        function void note_input(op_t kind, logic [SAMPLE_W-1:0] value);
            int            dev;
            level_result_t res;
            if (kind == OP_CAL)
            begin
                if (cal_pos != 0)
                    cal_acc = cal_acc + 14'(value);
                if (int'(cal_pos) >= CAL_COUNT - 1)
                begin
                    cur_offset = DEV_W'(int'(cal_acc) / (CAL_COUNT - 1) + int'(bias));
                    cal_pos    = '0;
                    cal_acc    = '0;
                end
                else
                    cal_pos = cal_pos + 4'd1;
            end
            else
            begin
                if (int'(value) >= int'(cur_offset))
                    dev = int'(value) - int'(cur_offset);
                else
                    dev = int'(cur_offset) - int'(value);
                tap_sum = tap_sum - SUM_W'(taps[WINDOW-1]) + SUM_W'(dev);
                for (int i = WINDOW - 1; i > 0; i--)
                    taps[i] = taps[i-1];
                taps[0] = DEV_W'(dev);
            end
            res.level  = DEV_W'(int'(tap_sum) / WINDOW);
            res.offset = cur_offset;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [DEV_W-1:0] level, logic [DEV_W-1:0] offset);
            level_result_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: level %0d offset %0d", level, offset);
                return;
            end
            want = expected_q.pop_front();
            if (level !== want.level || offset !== want.offset)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch: level %0d (want %0d) offset %0d (want %0d)",
                             level, want.level, offset, want.offset);
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                op = 1'b0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [DEV_W-1:0]    level;
    logic [DEV_W-1:0]    offset;
    logic                cfg_write = 1'b0;
    logic [SAMPLE_W-1:0] cfg_data = '0;

    level_scoreboard sb;
    int              cycle_count = 0;
    int              ready_left = 0;

    sound_level_offset_smoother dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .level     (level),
        .offset    (offset),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: ready is held high or low for random short and long stretches.
    always @(negedge clk)
    begin
        int r;
        if (ready_left > 0)
            ready_left--;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(0, 7);
            end
            else if (r < 75)
            begin
                out_ready  <= 1'b0;
                ready_left = $urandom_range(0, 2);
            end
            else if (r < 93)
            begin
                out_ready  <= 1'b1;
                ready_left = $urandom_range(20, 60);
            end
            else
            begin
                out_ready  <= 1'b0;
                ready_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(level, offset);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_sound_level_offset_smoother: errors");
        $finish;
    end

    function automatic int pick_gap(bit no_gaps);
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return SAMPLE_W'($urandom_range(0, 1023));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(op_t kind, logic [SAMPLE_W-1:0] value, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            op       <= 1'($urandom_range(0, 1));
            sample   <= SAMPLE_W'($urandom_range(0, 1023));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind;
        sample   <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(kind, value);
        @(negedge clk);
    endtask

    // Hold off the sender until every result has arrived.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_bias(logic [SAMPLE_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        cfg_data  <= SAMPLE_W'($urandom_range(0, 1023));
        sb.set_bias(value);
        @(negedge clk);
    endtask

    // Mostly complete calibration runs and measurement bursts, with some broken runs.
    task automatic run_phase(int n_items, bit no_gaps);
        int sent;
        int r;
        int len;
        op_t kind;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 35)
            begin
                kind = OP_CAL;
                len  = CAL_COUNT;
            end
            else if (r < 42)
            begin
                kind = OP_CAL;
                len  = $urandom_range(1, CAL_COUNT - 1);
            end
            else
            begin
                kind = OP_MEAS;
                len  = $urandom_range(1, 20);
            end
            repeat (len)
            begin
                send_item(kind, pick_sample(), pick_gap(no_gaps));
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Before any calibration the offset is zero, so deviations are raw samples.
        send_item(OP_MEAS, '1, 0);
        send_item(OP_MEAS, '0, 1);

        // A run split by a bias change; the bias at completion applies.
        repeat (5)
            send_item(OP_CAL, '1, pick_gap(1'b0));
        wait_idle();
        write_bias('1);
        repeat (5)
            send_item(OP_CAL, '1, pick_gap(1'b0));

        // Largest offset against the smallest sample gives the largest deviation.
        repeat (5)
            send_item(OP_MEAS, '0, 0);
        send_item(OP_MEAS, '1, 0);

        // Only the first sample of a run is large, and it is thrown away.
        wait_idle();
        write_bias('0);
        send_item(OP_CAL, '1, 0);
        repeat (CAL_COUNT - 1)
            send_item(OP_CAL, '0, pick_gap(1'b0));

        for (int p = 0; p < 10; p++)
        begin
            wait_idle();
            case (p)
                0: write_bias('0);
                1: write_bias('1);
                2: write_bias(SAMPLE_W'(BIAS_RESET));
                default: write_bias(SAMPLE_W'($urandom_range(0, 1023)));
            endcase
            run_phase(75, (p % 3) == 2);
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_sound_level_offset_smoother: clean");
        else
            $display("tb_sound_level_offset_smoother: errors");
        $finish;
    end

endmodule

>>> files.f
design/sls_pkg.sv
design/sls_cell.sv
design/sls_window.sv
design/sls_cal.sv
design/sound_level_offset_smoother.sv
tb/tb_sound_level_offset_smoother.sv
